// File: rtl/gpt_pkg.sv
package gpt_pkg;

  // F2DOT14 fixed point
  localparam int unsigned F2Shift = 14;
  localparam logic signed [15:0] F2One = 16'sd16384;
  localparam logic signed [47:0] F2Half = 48'sd8192;

  // Item kinds
  localparam logic KindStart = 1'b0;
  localparam logic KindPoint = 1'b1;

  // Component flag bit positions
  localparam int unsigned FlagXyArgs    = 1;
  localparam int unsigned FlagScale     = 3;
  localparam int unsigned FlagXyScale   = 6;
  localparam int unsigned FlagTwoByTwo  = 7;
  localparam int unsigned FlagScaledOfs = 11;

  // Default depth of the queue between front and back
  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic               kind;
    logic [15:0]        flags;
    logic signed [15:0] arg_x;
    logic signed [15:0] arg_y;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_01;
    logic signed [15:0] scale_10;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
  } out_item_t;

  // Classified item as it travels through the queue
  typedef struct packed {
    logic               kind;
    logic signed [15:0] mat_a;
    logic signed [15:0] mat_b;
    logic signed [15:0] mat_c;
    logic signed [15:0] mat_d;
    logic [31:0]        ofs_x0;
    logic [31:0]        ofs_x1;
    logic [31:0]        ofs_y0;
    logic [31:0]        ofs_y1;
    logic [31:0]        pen_x;
    logic [31:0]        pen_y;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
  } q_entry_t;

  // Rounded F2DOT14 product, floor((num * frac + half) >> 14), kept to 32 bits
  function automatic logic [31:0] f2_mul(input logic signed [31:0] num,
                                         input logic signed [15:0] frac);
    logic signed [47:0] prod;
    prod = num * frac;
    prod = prod + F2Half;
    return prod[F2Shift +: 32];
  endfunction

endpackage

// File: rtl/gpt_front.sv
module gpt_front (
  input  gpt_pkg::in_item_t in_item_i,
  output gpt_pkg::q_entry_t entry_o
);

  logic signed [15:0] ofs_x;
  logic signed [15:0] ofs_y;
  logic [31:0]        ofs_x_ext;
  logic [31:0]        ofs_y_ext;

  // Pick the component offset
  assign ofs_x = in_item_i.flags[gpt_pkg::FlagXyArgs] ? in_item_i.arg_x : 16'sd0;
  assign ofs_y = in_item_i.flags[gpt_pkg::FlagXyArgs] ? in_item_i.arg_y : 16'sd0;
  assign ofs_x_ext = {{16{ofs_x[15]}}, ofs_x};
  assign ofs_y_ext = {{16{ofs_y[15]}}, ofs_y};

  // Classify the item: matrix by flag priority, offset terms, pen and deltas
  always_comb begin
    entry_o         = '0;
    entry_o.kind    = in_item_i.kind;
    entry_o.mat_a   = gpt_pkg::F2One;
    entry_o.mat_b   = 16'sd0;
    entry_o.mat_c   = 16'sd0;
    entry_o.mat_d   = gpt_pkg::F2One;
    if (in_item_i.flags[gpt_pkg::FlagScale]) begin
      entry_o.mat_a = in_item_i.scale_x;
      entry_o.mat_d = in_item_i.scale_x;
    end else if (in_item_i.flags[gpt_pkg::FlagXyScale]) begin
      entry_o.mat_a = in_item_i.scale_x;
      entry_o.mat_d = in_item_i.scale_y;
    end else if (in_item_i.flags[gpt_pkg::FlagTwoByTwo]) begin
      entry_o.mat_a = in_item_i.scale_x;
      entry_o.mat_b = in_item_i.scale_01;
      entry_o.mat_c = in_item_i.scale_10;
      entry_o.mat_d = in_item_i.scale_y;
    end

    // Scale the offset once through the new matrix, or pass it straight
    if (in_item_i.flags[gpt_pkg::FlagScaledOfs]) begin
      entry_o.ofs_x0 = gpt_pkg::f2_mul(ofs_x_ext, entry_o.mat_a);
      entry_o.ofs_x1 = gpt_pkg::f2_mul(ofs_y_ext, entry_o.mat_c);
      entry_o.ofs_y0 = gpt_pkg::f2_mul(ofs_x_ext, entry_o.mat_b);
      entry_o.ofs_y1 = gpt_pkg::f2_mul(ofs_y_ext, entry_o.mat_d);
    end else begin
      entry_o.ofs_x0 = ofs_x_ext;
      entry_o.ofs_x1 = '0;
      entry_o.ofs_y0 = ofs_y_ext;
      entry_o.ofs_y1 = '0;
    end

    entry_o.pen_x   = in_item_i.origin_x;
    entry_o.pen_y   = in_item_i.origin_y;
    entry_o.delta_x = in_item_i.delta_x;
    entry_o.delta_y = in_item_i.delta_y;
  end

endmodule

// File: rtl/gpt_queue.sv
module gpt_queue #(
  parameter int unsigned Depth = gpt_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  gpt_pkg::q_entry_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              pop_valid_o,
  output gpt_pkg::q_entry_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  gpt_pkg::q_entry_t entries_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o      = (count_q == CntW'(Depth));
  assign pop_valid_o = (count_q != '0);
  assign pop_data_o  = entries_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue fill count exceeds depth");

  a_count_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> count_q == $past(count_q) + 1'b1)
    else $error("queue fill count did not grow on a lone push");

endmodule

// File: rtl/gpt_back.sv
module gpt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               entry_valid_i,
  input  gpt_pkg::q_entry_t  entry_i,
  output logic               entry_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gpt_pkg::out_item_t out_item_o
);

  // Component state
  logic [31:0]        sum_x_q, sum_y_q;
  logic [31:0]        shift_x_q, shift_y_q;
  logic [31:0]        pen_x_q, pen_y_q;
  logic signed [15:0] mat_a_q, mat_b_q, mat_c_q, mat_d_q;

  // Stage 1: new sums and the matrix they go through
  logic               v1_q;
  logic [31:0]        s1_sum_x_q, s1_sum_y_q, s1_ofs_x_q, s1_ofs_y_q;
  logic signed [15:0] s1_a_q, s1_b_q, s1_c_q, s1_d_q;

  // Stage 2: rounded products
  logic               v2_q;
  logic [31:0]        s2_ax_q, s2_cy_q, s2_bx_q, s2_dy_q, s2_ofs_x_q, s2_ofs_y_q;

  // Stage 3: output register
  logic               v3_q;
  gpt_pkg::out_item_t s3_q;

  logic        adv1, adv2, adv3;
  logic        pop_start, pop_point;
  logic [31:0] sum_x_d, sum_y_d;

  assign adv3 = !v3_q || out_ready_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign entry_pop_o = entry_valid_i && adv1;
  assign pop_start   = entry_pop_o && (entry_i.kind == gpt_pkg::KindStart);
  assign pop_point   = entry_pop_o && (entry_i.kind == gpt_pkg::KindPoint);

  assign sum_x_d = sum_x_q + {{16{entry_i.delta_x[15]}}, entry_i.delta_x};
  assign sum_y_d = sum_y_q + {{16{entry_i.delta_y[15]}}, entry_i.delta_y};

  // Hold component state; a start item reloads it and clears the sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q   <= '0;
      sum_y_q   <= '0;
      shift_x_q <= '0;
      shift_y_q <= '0;
      pen_x_q   <= '0;
      pen_y_q   <= '0;
      mat_a_q   <= gpt_pkg::F2One;
      mat_b_q   <= 16'sd0;
      mat_c_q   <= 16'sd0;
      mat_d_q   <= gpt_pkg::F2One;
    end else if (pop_start) begin
      sum_x_q   <= '0;
      sum_y_q   <= '0;
      shift_x_q <= entry_i.ofs_x0 + entry_i.ofs_x1;
      shift_y_q <= entry_i.ofs_y0 + entry_i.ofs_y1;
      pen_x_q   <= entry_i.pen_x;
      pen_y_q   <= entry_i.pen_y;
      mat_a_q   <= entry_i.mat_a;
      mat_b_q   <= entry_i.mat_b;
      mat_c_q   <= entry_i.mat_c;
      mat_d_q   <= entry_i.mat_d;
    end else if (pop_point) begin
      sum_x_q   <= sum_x_d;
      sum_y_q   <= sum_y_d;
    end
  end

  // Valid bits of the point pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= pop_point;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Advance the point payload
  always_ff @(posedge clk_i) begin
    if (adv1 && pop_point) begin
      s1_sum_x_q <= sum_x_d;
      s1_sum_y_q <= sum_y_d;
      s1_ofs_x_q <= shift_x_q + pen_x_q;
      s1_ofs_y_q <= shift_y_q + pen_y_q;
      s1_a_q     <= mat_a_q;
      s1_b_q     <= mat_b_q;
      s1_c_q     <= mat_c_q;
      s1_d_q     <= mat_d_q;
    end
    if (adv2 && v1_q) begin
      s2_ax_q    <= gpt_pkg::f2_mul(s1_sum_x_q, s1_a_q);
      s2_cy_q    <= gpt_pkg::f2_mul(s1_sum_y_q, s1_c_q);
      s2_bx_q    <= gpt_pkg::f2_mul(s1_sum_x_q, s1_b_q);
      s2_dy_q    <= gpt_pkg::f2_mul(s1_sum_y_q, s1_d_q);
      s2_ofs_x_q <= s1_ofs_x_q;
      s2_ofs_y_q <= s1_ofs_y_q;
    end
    if (adv3 && v2_q) begin
      s3_q.vertex_x <= s2_ax_q + s2_cy_q + s2_ofs_x_q;
      s3_q.vertex_y <= s2_bx_q + s2_dy_q + s2_ofs_y_q;
    end
  end

  assign out_valid_o = v3_q;
  assign out_item_o  = s3_q;

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_start |=> sum_x_q == '0 && sum_y_q == '0)
    else $error("start transfer did not clear the running sums");

  a_point_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_point |=> v1_q)
    else $error("point transfer did not enter the pipeline");

  a_start_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_start |=> !v1_q)
    else $error("start transfer produced a pipeline slot");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !adv2 |=> v2_q)
    else $error("stalled product stage lost its item");

endmodule

// File: rtl/glyph_point_transform_top.sv
// A point transferred in is written to the queue, then its sums, products and final
// adds are registered in stages 1, 2 and 3 before its vertex is presented.
// Throughput: one item per cycle unless out_ready_i holds the pipeline; start items
// yield no result and take one slot. The input stalls only when the queue
// (QueueDepth entries) is full. Reset clears the queue and pipeline, sets the
// identity matrix and zeroes offset, pen and running sums.
module glyph_point_transform_top #(
  parameter int unsigned QueueDepth = gpt_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gpt_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gpt_pkg::out_item_t out_item_o
);

  gpt_pkg::q_entry_t push_entry;
  gpt_pkg::q_entry_t pop_entry;
  logic              queue_full;
  logic              pop_valid;
  logic              pop;

  // Classify incoming items
  gpt_front u_front (
    .in_item_i (in_item_i),
    .entry_o   (push_entry)
  );

  // Decouple front from back
  gpt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (push_entry),
    .full_o      (queue_full),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_entry)
  );

  assign in_ready_o = !queue_full;

  // Apply state and transform points
  gpt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (pop_valid),
    .entry_i       (pop_entry),
    .entry_pop_o   (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_item_o    (out_item_o)
  );

endmodule

// File: dv/tb.sv
module tb;
  import gpt_pkg::*;

  localparam int unsigned RandomItems = 400;
  localparam int unsigned IdleLimit   = 3000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 20;

  typedef enum int {
    ReadyAlways,
    ReadyCoin,
    ReadySparse
  } ready_mode_e;

  // Tracks the glyph transform state and the vertices still owed by the block
  class vertex_tracker;
    logic [31:0]        sum_x, sum_y;
    logic [31:0]        ofs_x, ofs_y;
    logic [31:0]        pen_x, pen_y;
    logic signed [15:0] mat_a, mat_b, mat_c, mat_d;
    out_item_t          vertices_due[$];
    int                 errors;

    function new();
      sum_x  = '0;
      sum_y  = '0;
      ofs_x  = '0;
      ofs_y  = '0;
      pen_x  = '0;
      pen_y  = '0;
      mat_a  = F2One;
      mat_b  = '0;
      mat_c  = '0;
      mat_d  = F2One;
      errors = 0;
    endfunction

    // floor((num * frac + half) / 2^14), wrapped to 32 bits
    function logic [31:0] scale_round(logic [31:0] num, logic signed [15:0] frac);
      longint prod;
      prod = longint'($signed(num)) * longint'(frac) + 64'sd8192;
      prod = prod >>> 14;
      return prod[31:0];
    endfunction

    // Update the state on a start, or owe one vertex on a point
    function void note_item(in_item_t it);
      logic [31:0] arg_x, arg_y;
      out_item_t   vtx;
      if (it.kind == KindStart) begin
        mat_a = F2One;
        mat_b = '0;
        mat_c = '0;
        mat_d = F2One;
        if (it.flags[FlagScale]) begin
          mat_a = it.scale_x;
          mat_d = it.scale_x;
        end else if (it.flags[FlagXyScale]) begin
          mat_a = it.scale_x;
          mat_d = it.scale_y;
        end else if (it.flags[FlagTwoByTwo]) begin
          mat_a = it.scale_x;
          mat_b = it.scale_01;
          mat_c = it.scale_10;
          mat_d = it.scale_y;
        end
        arg_x = '0;
        arg_y = '0;
        if (it.flags[FlagXyArgs]) begin
          arg_x = {{16{it.arg_x[15]}}, it.arg_x};
          arg_y = {{16{it.arg_y[15]}}, it.arg_y};
        end
        if (it.flags[FlagScaledOfs]) begin
          ofs_x = scale_round(arg_x, mat_a) + scale_round(arg_y, mat_c);
          ofs_y = scale_round(arg_x, mat_b) + scale_round(arg_y, mat_d);
        end else begin
          ofs_x = arg_x;
          ofs_y = arg_y;
        end
        pen_x = it.origin_x;
        pen_y = it.origin_y;
        sum_x = '0;
        sum_y = '0;
      end else begin
        sum_x = sum_x + {{16{it.delta_x[15]}}, it.delta_x};
        sum_y = sum_y + {{16{it.delta_y[15]}}, it.delta_y};
        vtx.vertex_x = scale_round(sum_x, mat_a) + scale_round(sum_y, mat_c) + ofs_x + pen_x;
        vtx.vertex_y = scale_round(sum_x, mat_b) + scale_round(sum_y, mat_d) + ofs_y + pen_y;
        vertices_due.push_back(vtx);
      end
    endfunction

    // Compare one delivered vertex against the oldest one owed
    function void check_vertex(out_item_t got);
      out_item_t exp;
      if (vertices_due.size() == 0) begin
        $error("vertex with none pending: x %0d, y %0d", got.vertex_x, got.vertex_y);
        errors++;
        return;
      end
      exp = vertices_due.pop_front();
      if (got.vertex_x !== exp.vertex_x) begin
        $error("vertex_x: expected %0d, got %0d", exp.vertex_x, got.vertex_x);
        errors++;
      end
      if (got.vertex_y !== exp.vertex_y) begin
        $error("vertex_y: expected %0d, got %0d", exp.vertex_y, got.vertex_y);
        errors++;
      end
    endfunction

    function int outstanding();
      return vertices_due.size();
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  vertex_tracker tracker;
  bit            hold_req;
  bit            hold_done;
  int unsigned   idle_cycles;

  glyph_point_transform_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Check every vertex transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_vertex(out_item_o);
    end
  end

  // Abort when no transfer happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stall the output side in segments, with one long hold-off on request
  initial begin : receiver
    int          seg;
    ready_mode_e mode;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        @(negedge clk_i);
        out_ready_i = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
      end
      seg  = $urandom_range(1, 40);
      mode = ready_mode_e'($urandom_range(0, 2));
      repeat (seg) begin
        @(negedge clk_i);
        case (mode)
          ReadyAlways: out_ready_i = 1'b1;
          ReadyCoin:   out_ready_i = 1'($urandom_range(0, 1));
          default:     out_ready_i = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic in_item_t make_start(logic [15:0] flags, logic [15:0] ax, logic [15:0] ay,
                                          logic [15:0] sx, logic [15:0] sy,
                                          logic [15:0] s01, logic [15:0] s10,
                                          logic [31:0] ox, logic [31:0] oy);
    in_item_t it;
    it          = '0;
    it.kind     = KindStart;
    it.flags    = flags;
    it.arg_x    = ax;
    it.arg_y    = ay;
    it.scale_x  = sx;
    it.scale_y  = sy;
    it.scale_01 = s01;
    it.scale_10 = s10;
    it.origin_x = ox;
    it.origin_y = oy;
    return it;
  endfunction

  function automatic in_item_t make_point(logic [15:0] dx, logic [15:0] dy);
    in_item_t it;
    it         = '0;
    it.kind    = KindPoint;
    it.delta_x = dx;
    it.delta_y = dy;
    return it;
  endfunction

  // Mostly unity-like F2DOT14 values, sometimes anything
  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 4))
      0:       return 16'($urandom);
      1:       return F2One;
      2:       return -F2One;
      default: return 16'($urandom_range(0, 32767)) - 16'd16384;
    endcase
  endfunction

  function automatic logic [15:0] pick_delta();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 511)) - 16'd256;
  endfunction

  // Component start; noise fills every field but the kind at random
  function automatic in_item_t random_start(bit noise);
    in_item_t it;
    it      = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.kind = KindStart;
    if (noise) return it;
    it.flags = '0;
    case ($urandom_range(0, 3))
      0:       it.flags[FlagScale]    = 1'b1;
      1:       it.flags[FlagXyScale]  = 1'b1;
      2:       it.flags[FlagTwoByTwo] = 1'b1;
      default: ;
    endcase
    it.flags[FlagXyArgs]    = 1'($urandom_range(0, 1));
    it.flags[FlagScaledOfs] = 1'($urandom_range(0, 1));
    it.scale_x  = pick_scale();
    it.scale_y  = pick_scale();
    it.scale_01 = pick_scale();
    it.scale_10 = pick_scale();
    if ($urandom_range(0, 1)) begin
      it.arg_x = pick_delta();
      it.arg_y = pick_delta();
    end
    return it;
  endfunction

  // Point with random deltas and junk in the ignored fields
  function automatic in_item_t random_point();
    in_item_t it;
    it         = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.kind    = KindPoint;
    it.delta_x = pick_delta();
    it.delta_y = pick_delta();
    return it;
  endfunction

  // Offer one item and hold it until the transfer
  task automatic send_item(input in_item_t it);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_item_i  = it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_item(it);
  endtask

  task automatic pause_sender(input int cycles);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int           sent;
    int           burst;
    int           points_left;
    logic [15:0]  all_flags;
    tracker     = new();
    hold_req    = 1'b0;
    hold_done   = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Points before any start use the reset identity
    send_item(make_point(16'sd5, -16'sd3));
    send_item(make_point(16'sh7fff, 16'sh8000));
    // Offset args ignored without the xy-args flag; origin extremes
    send_item(make_start(16'h0000, 16'sh7fff, 16'sh8000, '0, '0, '0, '0,
                         32'h7fff_ffff, 32'h8000_0000));
    send_item(make_point(16'sh7fff, 16'sh7fff));
    send_item(make_point(16'sh8000, 16'sh8000));
    // Single scale at its most negative, unscaled offset
    send_item(make_start(16'h0001 << FlagXyArgs | 16'h0001 << FlagScale, 16'sh8000, 16'sh7fff,
                         16'sh8000, 16'sh7fff, '0, '0, '0, '0));
    send_item(make_point(16'sh8000, 16'sh8000));
    send_item(make_point(16'sh7fff, 16'sh0001));
    // x/y scale extremes with a scaled offset
    send_item(make_start(16'h0001 << FlagXyArgs | 16'h0001 << FlagXyScale |
                         16'h0001 << FlagScaledOfs, 16'sh7fff, 16'sh8000,
                         16'sh7fff, 16'sh8000, '0, '0, 32'd100, -32'sd100));
    send_item(make_point(16'sd3, -16'sd3));
    // 2x2 with half-unit diagonal entries: exact halves round upward
    send_item(make_start(16'h0001 << FlagXyArgs | 16'h0001 << FlagTwoByTwo |
                         16'h0001 << FlagScaledOfs, 16'sd1, -16'sd1,
                         16'sd8192, -16'sd8192, 16'sh8000, 16'sh7fff, '0, '0));
    send_item(make_point(16'sd1, 16'sd1));
    send_item(make_point(16'sd1, 16'sd1));
    send_item(make_point(-16'sd3, 16'sd0));
    // All flags set: single scale wins
    all_flags = 16'hffff;
    send_item(make_start(all_flags, 16'sd7, 16'sd9, 16'sd12000, -16'sd5000, 16'sd3000,
                         -16'sd2000, 32'hffff_ffff, 32'h0000_0001));
    send_item(make_point(16'sd40, -16'sd25));
    // Scale beats x/y scale, x/y scale beats 2x2
    send_item(make_start(16'h0001 << FlagScale | 16'h0001 << FlagXyScale, '0, '0,
                         16'sd20000, 16'sd4000, '0, '0, '0, '0));
    send_item(make_point(16'sd11, 16'sd13));
    send_item(make_start(16'h0001 << FlagXyScale | 16'h0001 << FlagTwoByTwo, '0, '0,
                         16'sd20000, 16'sd4000, 16'sd9999, -16'sd9999, '0, '0));
    send_item(make_point(16'sd11, 16'sd13));
    // Deltas on a start and junk fields on a point are ignored
    send_item(make_start(16'h0000, '0, '0, '0, '0, '0, '0, 32'hffff_ffff, 32'hffff_ffff)
              | in_item_t'({16'hffff, 16'hffff}));
    send_item(in_item_t'({$bits(in_item_t){1'b1}}));
    send_item(make_point(16'sd1, 16'sd1));

    // Components of random length, some noise, bursts with random gaps
    hold_req    = 1'b1;
    sent        = 0;
    points_left = 0;
    while (sent < RandomItems) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        if (points_left == 0) begin
          send_item(random_start($urandom_range(0, 9) == 0));
          points_left = $urandom_range(0, 12);
        end else begin
          send_item(random_point());
          points_left--;
        end
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
    end

    // Drain
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
